// File: design/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types, constants and small arithmetic helpers for the glass sampler.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned ONE_Q14   = 16384;
  localparam int unsigned ONE_Q16   = 65536;
  localparam int unsigned ONE_Q28   = 268435456;
  localparam logic [23:0] VALUE_MAX = 24'hFFFFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_IOR     = 3'd0;
  localparam logic [2:0] REG_REFL_R  = 3'd1;
  localparam logic [2:0] REG_REFL_G  = 3'd2;
  localparam logic [2:0] REG_REFL_B  = 3'd3;
  localparam logic [2:0] REG_TRANS_R = 3'd4;
  localparam logic [2:0] REG_TRANS_G = 3'd5;
  localparam logic [2:0] REG_TRANS_B = 3'd6;

  // Pipeline depths
  localparam int FRONT_STAGES = 7;
  localparam int SQRT_STEPS   = 15;
  localparam int DIV_STEPS    = 24;
  localparam int PIPE_LAT     = FRONT_STAGES + 1 + SQRT_STEPS + 2 + 1 + DIV_STEPS;

  typedef enum logic [1:0] {
    KIND_TIR     = 2'd0,
    KIND_FRESNEL = 2'd1,
    KIND_REFRACT = 2'd2
  } gbs_kind_t;

  // Values derived from the index of refraction
  typedef struct packed {
    logic [20:0] eta_up;   // Q1.20, 1/ior
    logic [21:0] eta_dn;   // Q2.20, ior
    logic [28:0] eta2_up;  // Q1.28
    logic [31:0] eta2_dn;  // Q4.28
    logic [15:0] r0;       // Q0.16
  } gbs_optics_t;

  // Sideband travelling alongside the square root
  typedef struct packed {
    gbs_kind_t          kind;
    logic [16:0]        pdf;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] dz;
    logic [31:0]        eta2;
  } gbs_side_t;

  // Result fields travelling alongside the divider
  typedef struct packed {
    gbs_kind_t          kind;
    logic [16:0]        pdf;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
  } gbs_res_t;

  function automatic logic [15:0] gbs_abs16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  // Negate, saturating the one case that does not fit
  function automatic logic signed [15:0] gbs_neg_sat(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  // (a*b) rounded half up to Q1.16
  function automatic logic [16:0] gbs_mulr(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + 34'd32768;
    return p[32:16];
  endfunction

  // Transmitted tangential component from eta*|d|, signed against d
  function automatic logic signed [15:0] gbs_refr_xy(input logic signed [15:0] d,
                                                     input logic [37:0] mag_p);
    logic [38:0] rnd;
    logic [18:0] mx;
    logic [15:0] mxs;
    rnd = {1'b0, mag_p} + 39'd524288;
    mx  = rnd[38:20];
    mxs = (mx > 19'd40000) ? 16'd40000 : mx[15:0];
    if (!d[15]) begin
      return (mxs > 16'd32768) ? 16'sh8000 : $signed(~mxs + 16'd1);
    end
    return (mxs > 16'd32767) ? 16'sh7FFF : $signed(mxs);
  endfunction

endpackage

// File: design/gbs_prep.sv
// ----------------------------------------------------------------------------
// gbs_prep
// Holds the index of refraction and derives eta, eta squared and r0 from it
// with a serial restoring divider after reset and after every write.
// ----------------------------------------------------------------------------
module gbs_prep import gbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ior_we,
  input  logic [13:0] ior_wdata,
  output gbs_optics_t optics,
  output logic        busy
);

  localparam int DIV_BITS = 33;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_ETA  = 5'b00100,
    ST_Q    = 5'b01000,
    ST_SQR  = 5'b10000
  } prep_state_t;

  prep_state_t state_r, state_nxt;
  logic [13:0] ior_r;
  logic [13:0] ior_c;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [14:0] rem_r, rem_nxt;
  logic [14:0] dvs_r, dvs_nxt;
  logic [20:0] eta_up_r, eta_up_nxt;
  logic [15:0] q_r, q_nxt;
  gbs_optics_t optics_r, optics_nxt;
  logic [15:0] acc;
  logic        fits;
  logic [14:0] rem_step;
  logic [32:0] quo_step;
  logic [41:0] eta_sq;
  logic [32:0] q_sq;
  logic [27:0] ior_sq;
  logic        last_bit;

  assign ior_c    = (ior_r < 14'd4096) ? 14'd4096 : ior_r;
  assign acc      = {rem_r, quo_r[32]};
  assign fits     = acc >= {1'b0, dvs_r};
  assign rem_step = fits ? 15'(acc - {1'b0, dvs_r}) : acc[14:0];
  assign quo_step = {quo_r[31:0], fits};
  assign last_bit = cnt_r == 6'(DIV_BITS - 1);
  assign eta_sq   = {21'd0, eta_up_r} * {21'd0, eta_up_r};
  assign q_sq     = 33'(q_r) * 33'(q_r) + 33'd32768;
  assign ior_sq   = ior_c * ior_c;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    eta_up_nxt = eta_up_r;
    q_nxt      = q_r;
    optics_nxt = optics_r;
    unique case (state_r)
      ST_INIT: begin
        quo_nxt   = 33'h1_0000_0000;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        dvs_nxt   = {1'b0, ior_c};
        state_nxt = ST_ETA;
      end
      ST_ETA: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 6'd1;
        if (last_bit) begin
          eta_up_nxt = quo_step[20:0];
          quo_nxt    = {3'd0, ior_c - 14'd4096, 16'd0};
          rem_nxt    = '0;
          cnt_nxt    = '0;
          dvs_nxt    = {1'b0, ior_c} + 15'd4096;
          state_nxt  = ST_Q;
        end
      end
      ST_Q: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 6'd1;
        if (last_bit) begin
          q_nxt     = quo_step[15:0];
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        optics_nxt.eta_up  = eta_up_r;
        optics_nxt.eta_dn  = {ior_c, 8'd0};
        optics_nxt.eta2_up = eta_sq[40:12];
        optics_nxt.eta2_dn = {ior_sq, 4'd0};
        optics_nxt.r0      = q_sq[31:16];
        state_nxt          = ST_IDLE;
      end
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
    if (ior_we) begin
      state_nxt = ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ior_r   <= 14'd6144;
    end else begin
      state_r <= state_nxt;
      if (ior_we) begin
        ior_r <= ior_wdata;
      end
    end
    cnt_r    <= cnt_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    eta_up_r <= eta_up_nxt;
    q_r      <= q_nxt;
    optics_r <= optics_nxt;
  end

  assign optics = optics_r;
  assign busy   = state_r != ST_IDLE;

endmodule

// File: design/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// Snell test, Schlick Fresnel term and event choice, one step per stage.
// ----------------------------------------------------------------------------
module gbs_front import gbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [15:0] in_dx,
  input  logic signed [15:0] in_dy,
  input  logic signed [15:0] in_dz,
  input  logic [15:0]        in_u,
  input  gbs_optics_t        optics,
  output logic               out_valid,
  output gbs_side_t          out_side,
  output logic [28:0]        out_cos2
);

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [15:0]        u;
    logic [21:0]        eta;
    logic [31:0]        eta2;
    logic [15:0]        adz;
    logic [30:0]        cz2;
    logic [16:0]        m;
    logic [37:0]        mxp;
    logic [37:0]        myp;
    logic [32:0]        prod;
    logic signed [15:0] ox_mir;
    logic signed [15:0] oy_mir;
    logic signed [15:0] ox_ref;
    logic signed [15:0] oy_ref;
    logic               tir;
    logic [28:0]        cos2;
    logic [16:0]        p;
    logic [16:0]        r;
  } fr_t;

  fr_t         st_r   [FRONT_STAGES];
  fr_t         st_nxt [FRONT_STAGES];
  logic        vld_r  [FRONT_STAGES];
  logic [15:0] c_clip;
  logic [28:0] sin2;
  logic [60:0] prod_full;
  logic        fres;
  gbs_side_t   side_r, side_nxt;
  logic [28:0] cos2_r;
  logic        out_vld_r;

  always_comb begin
    // Latch the operands and pick eta by the side of the surface
    st_nxt[0]      = '0;
    st_nxt[0].dx   = in_dx;
    st_nxt[0].dy   = in_dy;
    st_nxt[0].dz   = in_dz;
    st_nxt[0].u    = in_u;
    st_nxt[0].eta  = in_dz[15] ? optics.eta_dn : {1'b0, optics.eta_up};
    st_nxt[0].eta2 = in_dz[15] ? optics.eta2_dn : {3'd0, optics.eta2_up};
    st_nxt[0].adz  = gbs_abs16(in_dz);

    st_nxt[1]      = st_r[0];
    c_clip         = (st_r[0].adz > 16'(ONE_Q14)) ? 16'(ONE_Q14) : st_r[0].adz;
    st_nxt[1].cz2  = 31'(st_r[0].adz * st_r[0].adz);
    st_nxt[1].m    = {1'b0, 16'(ONE_Q14) - c_clip} << 2;
    st_nxt[1].mxp  = st_r[0].eta * gbs_abs16(st_r[0].dx);
    st_nxt[1].myp  = st_r[0].eta * gbs_abs16(st_r[0].dy);

    st_nxt[2]        = st_r[1];
    sin2             = (st_r[1].cz2 >= 31'(ONE_Q28)) ? '0 : 29'(31'(ONE_Q28) - st_r[1].cz2);
    prod_full        = st_r[1].eta2 * sin2;
    st_nxt[2].prod   = prod_full[60:28];
    st_nxt[2].p      = gbs_mulr(st_r[1].m, st_r[1].m);
    st_nxt[2].ox_mir = gbs_neg_sat(st_r[1].dx);
    st_nxt[2].oy_mir = gbs_neg_sat(st_r[1].dy);
    st_nxt[2].ox_ref = gbs_refr_xy(st_r[1].dx, st_r[1].mxp);
    st_nxt[2].oy_ref = gbs_refr_xy(st_r[1].dy, st_r[1].myp);

    st_nxt[3]      = st_r[2];
    st_nxt[3].tir  = st_r[2].prod > 33'(ONE_Q28);
    st_nxt[3].cos2 = 29'(33'(ONE_Q28) - st_r[2].prod);
    st_nxt[3].p    = gbs_mulr(st_r[2].p, st_r[2].m);

    st_nxt[4]   = st_r[3];
    st_nxt[4].p = gbs_mulr(st_r[3].p, st_r[3].m);

    st_nxt[5]   = st_r[4];
    st_nxt[5].p = gbs_mulr(st_r[4].p, st_r[4].m);

    st_nxt[6]   = st_r[5];
    st_nxt[6].r = {1'b0, optics.r0} +
                  gbs_mulr(17'(ONE_Q16) - {1'b0, optics.r0}, st_r[5].p);
  end

  // Choose the event
  always_comb begin
    fres          = {1'b0, st_r[6].u} < st_r[6].r;
    side_nxt.dz   = st_r[6].dz;
    side_nxt.eta2 = st_r[6].eta2;
    side_nxt.ox   = st_r[6].ox_mir;
    side_nxt.oy   = st_r[6].oy_mir;
    if (st_r[6].tir) begin
      side_nxt.kind = KIND_TIR;
      side_nxt.pdf  = 17'(ONE_Q16);
    end else if (fres) begin
      side_nxt.kind = KIND_FRESNEL;
      side_nxt.pdf  = st_r[6].r;
    end else begin
      side_nxt.kind = KIND_REFRACT;
      side_nxt.pdf  = 17'(ONE_Q16) - st_r[6].r;
      side_nxt.ox   = st_r[6].ox_ref;
      side_nxt.oy   = st_r[6].oy_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < FRONT_STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_vld_r <= vld_r[FRONT_STAGES-1];
    end
    for (int i = 0; i < FRONT_STAGES; i++) begin
      st_r[i] <= st_nxt[i];
    end
    side_r <= side_nxt;
    cos2_r <= st_r[6].cos2;
  end

  assign out_valid = out_vld_r;
  assign out_side  = side_r;
  assign out_cos2  = cos2_r;

endmodule

// File: design/gbs_isqrt.sv
// ----------------------------------------------------------------------------
// gbs_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gbs_isqrt import gbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [28:0] in_rad,
  input  gbs_side_t   in_side,
  output logic        out_valid,
  output logic [14:0] out_root,
  output gbs_side_t   out_side
);

  logic        vld_r  [SQRT_STEPS];
  logic [29:0] rad_r  [SQRT_STEPS];
  logic [17:0] rem_r  [SQRT_STEPS];
  logic [14:0] root_r [SQRT_STEPS];
  gbs_side_t   side_r [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    logic        vld_i;
    logic [29:0] rad_i;
    logic [17:0] rem_i;
    logic [14:0] root_i;
    gbs_side_t   side_i;
    logic [17:0] acc;
    logic [17:0] trial;
    logic        fits;

    if (s == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rad_i  = {1'b0, in_rad};
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[s-1];
      assign rad_i  = rad_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign side_i = side_r[s-1];
    end

    assign acc   = {rem_i[15:0], rad_i[29:28]};
    assign trial = {1'b0, root_i, 2'b01};
    assign fits  = acc >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
      rad_r[s]  <= {rad_i[27:0], 2'b00};
      rem_r[s]  <= fits ? (acc - trial) : acc;
      root_r[s] <= {root_i[13:0], fits};
      side_r[s] <= side_i;
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

// File: design/gbs_vdiv.sv
// ----------------------------------------------------------------------------
// gbs_vdiv
// Three-lane pipelined restoring divider with a saturating 24-bit quotient.
// ----------------------------------------------------------------------------
module gbs_vdiv import gbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [58:0] in_num [3],
  input  logic [47:0] in_den,
  input  gbs_res_t    in_res,
  output logic        out_valid,
  output logic [23:0] out_quot [3],
  output gbs_res_t    out_res
);

  logic        s_vld_r;
  logic        s_ovf_r [3];
  logic [47:0] s_rem_r [3];
  logic [23:0] s_lq_r  [3];
  logic [47:0] s_den_r;
  gbs_res_t    s_res_r;

  logic        vld_r [DIV_STEPS];
  logic        ovf_r [DIV_STEPS][3];
  logic [47:0] rem_r [DIV_STEPS][3];
  logic [23:0] lq_r  [DIV_STEPS][3];
  logic [47:0] den_r [DIV_STEPS];
  gbs_res_t    res_r [DIV_STEPS];

  // Split off the high part and flag quotients that cannot fit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= in_valid;
    end
    for (int k = 0; k < 3; k++) begin
      s_ovf_r[k] <= {13'd0, in_num[k][58:24]} >= in_den;
      s_rem_r[k] <= {13'd0, in_num[k][58:24]};
      s_lq_r[k]  <= in_num[k][23:0];
    end
    s_den_r <= in_den;
    s_res_r <= in_res;
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic        vld_i;
    logic [47:0] den_i;
    gbs_res_t    res_i;

    if (s == 0) begin : g_first
      assign vld_i = s_vld_r;
      assign den_i = s_den_r;
      assign res_i = s_res_r;
    end else begin : g_next
      assign vld_i = vld_r[s-1];
      assign den_i = den_r[s-1];
      assign res_i = res_r[s-1];
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic        ovf_i;
      logic [47:0] rem_i;
      logic [23:0] lq_i;
      logic [48:0] acc;
      logic        fits;

      if (s == 0) begin : g_first
        assign ovf_i = s_ovf_r[k];
        assign rem_i = s_rem_r[k];
        assign lq_i  = s_lq_r[k];
      end else begin : g_next
        assign ovf_i = ovf_r[s-1][k];
        assign rem_i = rem_r[s-1][k];
        assign lq_i  = lq_r[s-1][k];
      end

      assign acc  = {rem_i, lq_i[23]};
      assign fits = acc >= {1'b0, den_i};

      always_ff @(posedge clk) begin
        ovf_r[s][k] <= ovf_i;
        rem_r[s][k] <= fits ? 48'(acc - {1'b0, den_i}) : acc[47:0];
        lq_r[s][k]  <= {lq_i[22:0], fits};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
      den_r[s] <= den_i;
      res_r[s] <= res_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_quot[k] = ovf_r[DIV_STEPS-1][k] ? VALUE_MAX : lq_r[DIV_STEPS-1][k];
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_res   = res_r[DIV_STEPS-1];

endmodule

// File: design/glass_bsdf_sample_top.sv
// ----------------------------------------------------------------------------
// glass_bsdf_sample_top
// Smooth glass sampler in the local shading frame: Snell test, Schlick
// Fresnel choice, mirrored or refracted direction, pdf and colour values.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ---------------------------------------------
//  input     start, busy        in_dir_x/y/z, in_random_u
//  result    out_valid (strobe) out_dir_x/y/z, out_sample_pdf, out_value_*,
//                               out_event_kind
//  config    cfg_we             cfg_index, cfg_wdata
//
//  A transaction enters on every cycle with start high and busy low; its
//  result strobes out after 8 front stages, 15 square root stages, select
//  and multiply stages and 25 divider stages.
//  Throughput is one transaction per clock while busy is low; the receiver
//  cannot stall, so nothing in the pipeline ever holds.
//  After reset and after every write of the index of refraction, busy stays
//  high while a serial divider derives eta and r0.
//
module glass_bsdf_sample_top import gbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic [15:0]        in_random_u,
  output logic               out_valid,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic [16:0]        out_sample_pdf,
  output logic [23:0]        out_value_red,
  output logic [23:0]        out_value_green,
  output logic [23:0]        out_value_blue,
  output logic [1:0]         out_event_kind,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic        in_fire;
  logic        prep_busy;
  gbs_optics_t optics;

  // Colour registers: index 0 of each array is red
  logic [15:0] refl_r [3];
  logic [15:0] trans_r [3];

  logic        fr_valid;
  gbs_side_t   fr_side;
  logic [28:0] fr_cos2;

  logic        sq_valid;
  logic [14:0] sq_root;
  gbs_side_t   sq_side;

  // Select stage
  logic               sel_refr;
  logic signed [15:0] zt_s;
  logic [15:0]        zabs;
  gbs_res_t           sel_res_nxt;
  logic               sel_vld_r;
  gbs_res_t           sel_res_r;
  logic [15:0]        sel_zmag_r, sel_zmag_nxt;
  logic               sel_refr_r;
  logic [31:0]        sel_eta2_r;
  logic [15:0]        sel_col_r [3];

  // Multiply stage
  logic [32:0] num_c [3];
  logic [47:0] den_nxt;
  logic        mul_vld_r;
  logic [58:0] mul_num_r [3];
  logic [47:0] mul_den_r;
  gbs_res_t    mul_res_r;

  logic        vd_valid;
  logic [23:0] vd_quot [3];
  gbs_res_t    vd_res;

  assign in_fire = start && !prep_busy;
  assign busy    = prep_busy;

  // Configuration writes; the index of refraction lives in the prep unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        refl_r[k]  <= 16'hFFFF;
        trans_r[k] <= 16'hFFFF;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REFL_R:  refl_r[0]  <= cfg_wdata;
        REG_REFL_G:  refl_r[1]  <= cfg_wdata;
        REG_REFL_B:  refl_r[2]  <= cfg_wdata;
        REG_TRANS_R: trans_r[0] <= cfg_wdata;
        REG_TRANS_G: trans_r[1] <= cfg_wdata;
        REG_TRANS_B: trans_r[2] <= cfg_wdata;
        default: begin
          // index of refraction or unused index: nothing to hold here
        end
      endcase
    end
  end

  gbs_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .ior_we    (cfg_we && (cfg_index == REG_IOR)),
    .ior_wdata (cfg_wdata[13:0]),
    .optics    (optics),
    .busy      (prep_busy)
  );

  // Snell test, Fresnel term and event choice
  gbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_dx     (in_dir_x),
    .in_dy     (in_dir_y),
    .in_dz     (in_dir_z),
    .in_u      (in_random_u),
    .optics    (optics),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_cos2  (fr_cos2)
  );

  // Transmitted cosine; the result is only used for refraction
  gbs_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_rad    (fr_cos2),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Select the output z, its magnitude and the colour set
  always_comb begin
    sel_refr         = sq_side.kind == KIND_REFRACT;
    zt_s             = $signed({1'b0, sq_root});
    sel_res_nxt.kind = sq_side.kind;
    sel_res_nxt.pdf  = sq_side.pdf;
    sel_res_nxt.ox   = sq_side.ox;
    sel_res_nxt.oy   = sq_side.oy;
    if (sel_refr) begin
      sel_res_nxt.oz = sq_side.dz[15] ? zt_s : -zt_s;
    end else begin
      sel_res_nxt.oz = sq_side.dz;
    end
    zabs         = gbs_abs16(sel_res_nxt.oz);
    // a grazing result divides by one step rather than zero
    sel_zmag_nxt = (zabs == 16'd0) ? 16'd1 : zabs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      sel_vld_r <= sq_valid;
      mul_vld_r <= sel_vld_r;
    end
    sel_res_r  <= sel_res_nxt;
    sel_zmag_r <= sel_zmag_nxt;
    sel_refr_r <= sel_refr;
    sel_eta2_r <= sq_side.eta2;
    for (int k = 0; k < 3; k++) begin
      sel_col_r[k] <= sel_refr ? trans_r[k] : refl_r[k];
    end
  end

  // Numerators and the shared denominator: refraction divides by |z|*eta^2
  // with the numerator raised by 2^26, reflection by 4*|z|
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_c[k] = sel_res_r.pdf * sel_col_r[k];
    end
    den_nxt = sel_refr_r ? (sel_zmag_r * sel_eta2_r) : {30'd0, sel_zmag_r, 2'b00};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mul_num_r[k] <= sel_refr_r ? {num_c[k], 26'd0} : {26'd0, num_c[k]};
    end
    mul_den_r <= den_nxt;
    mul_res_r <= sel_res_r;
  end

  gbs_vdiv u_vdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_vld_r),
    .in_num    (mul_num_r),
    .in_den    (mul_den_r),
    .in_res    (mul_res_r),
    .out_valid (vd_valid),
    .out_quot  (vd_quot),
    .out_res   (vd_res)
  );

  assign out_valid       = vd_valid;
  assign out_dir_x       = vd_res.ox;
  assign out_dir_y       = vd_res.oy;
  assign out_dir_z       = vd_res.oz;
  assign out_sample_pdf  = vd_res.pdf;
  assign out_value_red   = vd_quot[0];
  assign out_value_green = vd_quot[1];
  assign out_value_blue  = vd_quot[2];
  assign out_event_kind  = vd_res.kind;

  // Every accepted transaction leaves exactly once, a fixed time later
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##PIPE_LAT out_valid)
    else $error("accepted transaction produced no result");

  a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, PIPE_LAT))
    else $error("result without a matching accepted transaction");

  a_tir_pdf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == KIND_TIR)) |-> (out_sample_pdf == 17'(ONE_Q16)))
    else $error("total internal reflection with pdf other than one");

endmodule
